[src/nhu_pkg.sv]
// Shared types, constants and hash step functions for the name hash identifier block.
package nhu_pkg;

    // Seeds and mixing constants.
    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [63:0] GOLDEN_K  = 64'h9e3779b97f4a7c15;

    // Version and variant marks of the identifier.
    localparam logic [7:0] VERSION_KEEP = 8'h0f;
    localparam logic [7:0] VERSION_SET  = 8'h50;
    localparam logic [7:0] VARIANT_KEEP = 8'h3f;
    localparam logic [7:0] VARIANT_SET  = 8'h80;

    // Control handed from the input stage to the hash core.
    typedef struct packed {
        logic step;     // the staged item moves on this cycle
        logic present;  // the staged item carries a byte
        logic last;     // the staged item ends the name
    } hash_ctl_t;

    // FNV-1a step. The prime is 2^40 + 0x1b3, so the multiply is a sum of shifts.
    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        x = acc ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // Add-shift-xor mix step.
    function automatic logic [63:0] mix_step(input logic [63:0] acc, input logic [7:0] b);
        return acc ^ ({56'd0, b} + GOLDEN_K + (acc << 6) + (acc >> 2));
    endfunction

endpackage

[src/name_hash_uuid.sv]
// Top level of the name hash identifier block: input stage, hash core and result register.
//
//   Channel  Direction  Ports                                    Moves
//   s_       in         s_name_byte, s_byte_present, s_last_byte one name byte per transfer
//   m_       out        m_id_first_half, m_id_second_half        one identifier per name
//
// One byte per cycle is sustained unless an item that ends a name waits on a full result
// register. A byte is registered on its transfer and folded when the staged item moves on;
// its identifier passes from the input stage through the result register to m_.
// The accumulator update is one shift-add tree per accumulator.
// Reset (aresetn low, synchronous) empties both stages and loads the seeds.
// A stalled m_ holds back only items that end a name; other bytes keep flowing until one reaches the input stage.
module name_hash_uuid (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_name_byte,
    input  logic        s_byte_present,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_id_first_half,
    output logic [63:0] m_id_second_half
);
    import nhu_pkg::*;

    logic        st_valid_reg;
    logic        st_valid_next;
    logic [7:0]  st_byte_reg;
    logic        st_present_reg;
    logic        st_last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_first_reg;
    logic [63:0] out_second_reg;
    logic        out_free;
    logic        st_advance;
    logic        emit;
    hash_ctl_t   ctl;
    logic [63:0] id_first;
    logic [63:0] id_second;

    // The staged item moves on unless it ends a name and the result register is full.
    always_comb begin
        out_free    = !out_valid_reg || m_ready;
        st_advance  = st_valid_reg && (!st_last_reg || out_free);
        emit        = st_advance && st_last_reg;
        s_ready     = !st_valid_reg || st_advance;
        ctl.step    = st_advance;
        ctl.present = st_present_reg;
        ctl.last    = st_last_reg;
    end

    // Input stage.
    always_comb begin
        st_valid_next = st_valid_reg;
        if (s_valid && s_ready) begin
            st_valid_next = 1'b1;
        end else if (st_advance) begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            st_byte_reg    <= s_name_byte;
            st_present_reg <= s_byte_present;
            st_last_reg    <= s_last_byte;
        end
    end

    nhu_hash_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .name_byte      (st_byte_reg),
        .id_first_half  (id_first),
        .id_second_half (id_second)
    );

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_first_reg  <= id_first;
            out_second_reg <= id_second;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_id_first_half  = out_first_reg;
    assign m_id_second_half = out_second_reg;

`ifndef ASSERT_OFF
    // An item that ends a name and moves on leaves a result behind.
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("identifier lost after end of name");

    // Every result carries version nibble 5.
    a_version: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_id_first_half[55:52] == 4'h5))
        else $error("version nibble missing");

    // Every result carries variant bits 10.
    a_variant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_id_second_half[7:6] == 2'b10))
        else $error("variant bits missing");

    // An empty input stage always takes a transfer.
    a_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !st_valid_reg |-> s_ready)
        else $error("empty input stage refused a transfer");
`endif

endmodule

[src/nhu_hash_core.sv]
// Hash accumulators with their update logic and identifier formatting.
module nhu_hash_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  nhu_pkg::hash_ctl_t ctl,
    input  logic [7:0]        name_byte,
    output logic [63:0]       id_first_half,
    output logic [63:0]       id_second_half
);
    import nhu_pkg::*;

    logic [63:0] fnv_accum_reg;
    logic [63:0] fnv_accum_next;
    logic [63:0] mix_accum_reg;
    logic [63:0] mix_accum_next;
    logic [63:0] fnv_absorbed;
    logic [63:0] mix_absorbed;
    logic [7:0]  version_byte;
    logic [7:0]  variant_byte;

    // Fold the staged byte into both accumulators when it is present.
    always_comb begin
        fnv_absorbed = ctl.present ? fnv_step(fnv_accum_reg, name_byte) : fnv_accum_reg;
        mix_absorbed = ctl.present ? mix_step(mix_accum_reg, name_byte) : mix_accum_reg;
    end

    // The end of a name returns both accumulators to their seeds.
    always_comb begin
        fnv_accum_next = fnv_accum_reg;
        mix_accum_next = mix_accum_reg;
        if (ctl.step) begin
            if (ctl.last) begin
                fnv_accum_next = FNV_BASIS;
                mix_accum_next = FNV_PRIME;
            end else begin
                fnv_accum_next = fnv_absorbed;
                mix_accum_next = mix_absorbed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fnv_accum_reg <= FNV_BASIS;
            mix_accum_reg <= FNV_PRIME;
        end else begin
            fnv_accum_reg <= fnv_accum_next;
            mix_accum_reg <= mix_accum_next;
        end
    end

    // Stamp the version nibble into bits 55:52 of the first half and the variant bits into bits 7:6 of the second half.
    always_comb begin
        version_byte   = (fnv_absorbed[55:48] & VERSION_KEEP) | VERSION_SET;
        variant_byte   = (mix_absorbed[7:0] & VARIANT_KEEP) | VARIANT_SET;
        id_first_half  = {fnv_absorbed[63:56], version_byte, fnv_absorbed[47:0]};
        id_second_half = {mix_absorbed[63:8], variant_byte};
    end

endmodule

[tb/sv/tb_name_hash_uuid.sv]
// Self-checking testbench for the name hash identifier block, with its scoreboard class.

// Scoreboard: a bit-true copy of both accumulators and the identifiers still expected.
class name_id_board;

    typedef struct packed {
        logic [63:0] first_half;
        logic [63:0] second_half;
    } name_id_t;

    localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_PRIME   = 64'd1099511628211;
    localparam logic [63:0] GOLDEN_RATIO = 64'h9e3779b97f4a7c15;

    logic [63:0] fnv_acc;
    logic [63:0] mix_acc;
    name_id_t    expected_ids[$];
    int          mismatches;

    function new();
        fnv_acc    = OFFSET_BASIS;
        mix_acc    = HASH_PRIME;
        mismatches = 0;
    endfunction

    // Fold one byte into both accumulators.
    function void fold_byte(logic [7:0] b);
        logic [63:0] wide;
        logic [63:0] sum;
        wide    = {56'd0, b};
        fnv_acc = (fnv_acc ^ wide) * HASH_PRIME;
        sum     = wide + GOLDEN_RATIO + (mix_acc << 6) + (mix_acc >> 2);
        mix_acc = mix_acc ^ sum;
    endfunction

    // Note an accepted input transfer; the end of a name queues an identifier.
    function void absorb_item(logic [7:0] b, logic present, logic last);
        name_id_t id;
        logic [7:0] mark;
        if (present) begin
            fold_byte(b);
        end
        if (last) begin
            mark = (fnv_acc[55:48] & 8'h0f) | 8'h50;
            id.first_half = {fnv_acc[63:56], mark, fnv_acc[47:0]};
            mark = (mix_acc[7:0] & 8'h3f) | 8'h80;
            id.second_half = {mix_acc[63:8], mark};
            expected_ids.insert(expected_ids.size(), id);
            fnv_acc = OFFSET_BASIS;
            mix_acc = HASH_PRIME;
        end
    endfunction

    // Report a mismatch in full for the first ten, then only count.
    function void flag(string what, logic [63:0] want, logic [63:0] got);
        if (mismatches < 10) begin
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
        end
        mismatches++;
    endfunction

    // Compare one result transfer against the oldest expected identifier.
    function void check_id(logic [63:0] first_half, logic [63:0] second_half);
        name_id_t id;
        if (expected_ids.size() == 0) begin
            flag("unexpected identifier, first half", 64'd0, first_half);
            return;
        end
        id = expected_ids.pop_front();
        if (first_half !== id.first_half) begin
            flag("id_first_half", id.first_half, first_half);
        end
        if (second_half !== id.second_half) begin
            flag("id_second_half", id.second_half, second_half);
        end
    endfunction

    function int pending();
        return expected_ids.size();
    endfunction

endclass

module tb_name_hash_uuid;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_ITEMS = 850;
    localparam int HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_name_byte;
    logic        s_byte_present;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_id_first_half;
    logic [63:0] m_id_second_half;

    name_id_board board = new();

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent  = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    int hold_left   = 0;

    name_hash_uuid u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_name_byte      (s_name_byte),
        .s_byte_present   (s_byte_present),
        .s_last_byte      (s_last_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_id_first_half  (m_id_first_half),
        .m_id_second_half (m_id_second_half)
    );

    // 100 MHz clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin
        #2_000_000;
        $display("** name_hash_uuid: FAILED **");
        $finish;
    end

    // Sample both channels on the clock edge and feed the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            board.absorb_item(s_name_byte, s_byte_present, s_last_byte);
        end
        if (aresetn && m_valid && m_ready) begin
            board.check_id(m_id_first_half, m_id_second_half);
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item, with random idle cycles first, and wait for its transfer.
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) begin
                @(posedge aclk);
            end
        end
        s_valid        <= 1'b1;
        s_name_byte    <= b;
        s_byte_present <= present;
        s_last_byte    <= last;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (present || last) begin
            items_sent++;
        end
    endtask

    // One random name: mostly short, sometimes empty or long, with ignored items mixed in.
    task automatic send_random_name();
        int len;
        int kind;
        bit closed;
        kind   = $urandom_range(99);
        closed = 1'b0;
        if (kind < 6) begin
            len = 0;
        end else if (kind < 94) begin
            len = $urandom_range(1, 8);
        end else begin
            len = $urandom_range(9, 40);
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            if (i == len - 1 && $urandom_range(99) >= 10) begin
                send_item(8'($urandom), 1'b1, 1'b1);
                closed = 1'b1;
            end else begin
                send_item(8'($urandom), 1'b1, 1'b0);
            end
        end
        // An empty name, or a name closed by an item without a byte.
        if (!closed) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Main sequence: reset, directed names, then three phases of random names, two with idling and one with a hold-off.
    initial begin
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_name_byte    <= 8'h00;
        s_byte_present <= 1'b0;
        s_last_byte    <= 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty name straight after reset.
        send_item(8'h5a, 1'b0, 1'b1);
        // Single-byte names at the byte extremes.
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        // A two-byte name with an ignored item in the middle.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hc3, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b1);
        // Empty name right after an emission.
        send_item(8'hff, 1'b0, 1'b1);
        // Bytes followed by an end-of-name item that carries no byte.
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // A longer name over varied bit patterns.
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hfe, 1'b1, 1'b0);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b1);
        // Back-to-back empty names.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 12;
        rx_idle_pct = 64;
        while (items_sent < TOTAL_ITEMS / 3) begin
            send_random_name();
        end

        // The other way round.
        tx_idle_pct = 64;
        rx_idle_pct = 12;
        while (items_sent < 2 * TOTAL_ITEMS / 3) begin
            send_random_name();
        end

        // No idling; a long receiver hold-off while one-byte names keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
        repeat (40) begin
            send_item(8'($urandom), 1'b1, 1'b1);
        end
        while (items_sent < TOTAL_ITEMS) begin
            send_random_name();
        end
        s_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        if (board.mismatches == 0) begin
            $display("** name_hash_uuid: PASSED **");
        end else begin
            $display("** name_hash_uuid: FAILED **");
        end
        $finish;
    end

endmodule
